>>> design/reverse_delay_crossfade_macros.svh
// Assertion macros used by the reverse delay crossfade core (rdc_core.sv).
`ifndef REVERSE_DELAY_CROSSFADE_MACROS_SVH
`define REVERSE_DELAY_CROSSFADE_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define RDC_CHECK(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdc check failed");

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define RDC_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdc next-cycle check failed");

`endif

>>> design/rdc_pkg.sv
// Types and constants shared by the reverse delay crossfade modules.
package rdc_pkg;

    localparam int DLEN_W = 18;
    localparam int GAIN_W = 17;
    localparam int RAMP_W = 15;
    localparam int STEP_W = 24;
    localparam int POS_W = 17;
    localparam int LVL_W = 24;
    localparam int MUL_B_W = 25;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int MIN_LEN = 4;

    localparam logic [LVL_W-1:0] UNITY_Q23 = 24'h80_0000;
    localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'h1_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_WET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RAMP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_STEP = 3'd4;

    typedef struct packed {
        logic [DLEN_W-1:0] delay_length;
        logic [GAIN_W-1:0] feedback_gain;
        logic [GAIN_W-1:0] mix_wet;
        logic [RAMP_W-1:0] window_ramp;
        logic [STEP_W-1:0] window_step;
    } cfg_regs_t;

    localparam cfg_regs_t CFG_RESET = '{
        delay_length: 18'd24000,
        feedback_gain: 17'd0,
        mix_wet: 17'd32768,
        window_ramp: 15'd3000,
        window_step: 24'd2796
    };

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FB,
        S_STORE,
        S_WIN,
        S_WET,
        S_MIX,
        S_DONE
    } state_t;

endpackage

>>> design/reverse_delay_crossfade.sv
// Top level of the reverse delay crossfade: register file, sequencer and delay RAM.
// An accepted item passes through the steps FB, STORE, WIN, WET, MIX and DONE; no
// new item is taken until it leaves DONE, which waits while the output is stalled.
// FB, STORE, WIN and MIX share one multiplier. After reset the delay RAM is cleared,
// one entry per cycle for all MAX_DELAY entries (131072 at default), taking no item;
// config writes are accepted at any time and restart the write position and window.
module reverse_delay_crossfade #(
    parameter int MAX_DELAY = 131072,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rdc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [SAMPLE_BITS-1:0]      in_sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [SAMPLE_BITS-1:0]      out_sample,
    output logic [rdc_pkg::POS_W-1:0]          delay_position
);

    localparam int AW = $clog2(MAX_DELAY);

    rdc_pkg::cfg_regs_t cfg_reg;
    logic               cfg_write;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= rdc_pkg::CFG_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rdc_pkg::CFG_DELAY_LENGTH:
                    cfg_reg.delay_length <= cfg_data[rdc_pkg::DLEN_W-1:0];
                rdc_pkg::CFG_FEEDBACK_GAIN:
                    cfg_reg.feedback_gain <= cfg_data[rdc_pkg::GAIN_W-1:0];
                rdc_pkg::CFG_MIX_WET:
                    cfg_reg.mix_wet <= cfg_data[rdc_pkg::GAIN_W-1:0];
                rdc_pkg::CFG_WINDOW_RAMP:
                    cfg_reg.window_ramp <= cfg_data[rdc_pkg::RAMP_W-1:0];
                rdc_pkg::CFG_WINDOW_STEP:
                    cfg_reg.window_step <= cfg_data[rdc_pkg::STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    rdc_core #(
        .MAX_DELAY   (MAX_DELAY),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .restart        (cfg_write),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_sample      (in_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_sample     (out_sample),
        .delay_position (delay_position),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata)
    );

    rdc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_DELAY)
    ) u_delay_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

>>> design/rdc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module rdc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 131072
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/rdc_core.sv
// Sequencer and shared-multiplier datapath of the reverse delay crossfade.
`include "reverse_delay_crossfade_macros.svh"

module rdc_core #(
    parameter int MAX_DELAY = 131072,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rdc_pkg::cfg_regs_t                  cfg,
    input  logic                                restart,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       in_sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]       out_sample,
    output logic [rdc_pkg::POS_W-1:0]           delay_position,
    output logic                                ram_we,
    output logic [$clog2(MAX_DELAY)-1:0]        ram_waddr,
    output logic [SAMPLE_BITS-1:0]              ram_wdata,
    output logic [$clog2(MAX_DELAY)-1:0]        ram_raddr,
    input  logic [SAMPLE_BITS-1:0]              ram_rdata
);

    localparam int SW = SAMPLE_BITS;
    localparam int AW = $clog2(MAX_DELAY);
    localparam int LW = $clog2(MAX_DELAY + 1);
    localparam int CNTW = $clog2(MAX_DELAY / 2 + 2);
    localparam int EXTW = (LW > rdc_pkg::DLEN_W) ? LW : rdc_pkg::DLEN_W;
    localparam int RW = (CNTW > rdc_pkg::RAMP_W) ? CNTW : rdc_pkg::RAMP_W;
    localparam int LVLW = rdc_pkg::LVL_W;
    localparam int GW = rdc_pkg::GAIN_W;
    localparam int MB = rdc_pkg::MUL_B_W;
    localparam int PW = SW + MB;
    localparam int POS_W = rdc_pkg::POS_W;

    localparam logic signed [PW-1:0] SAT_HI = {{(PW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [PW-1:0] SAT_LO = {{(PW-SW+1){1'b1}}, {(SW-1){1'b0}}};
    localparam logic signed [PW-1:0] RND16 = {{(PW-16){1'b0}}, 1'b1, 15'b0};
    localparam logic signed [PW-1:0] RND23 = {{(PW-23){1'b0}}, 1'b1, 22'b0};

    function automatic logic signed [SW-1:0] sat_fn(input logic signed [PW-1:0] v);
        logic signed [SW-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[SW-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[SW-1:0];
        end
        else
        begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

    rdc_pkg::state_t state_reg;
    rdc_pkg::state_t state_next;

    logic [AW-1:0]            clr_reg;
    logic [AW-1:0]            wp_reg;
    logic [CNTW-1:0]          cnt_reg;
    logic [LVLW-1:0]          level_reg;
    logic signed [SW-1:0]     feedback_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;

    logic signed [SW-1:0]     x_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [LW-1:0]            len_reg;
    logic [CNTW-1:0]          full_reg;
    logic [CNTW-1:0]          ramp_reg;
    logic [CNTW-1:0]          fmr_reg;
    logic [LVLW-1:0]          step_reg;
    logic [GW-1:0]            wg_reg;
    logic                     tap_ok_reg;
    logic signed [PW-1:0]     prod_reg;
    logic signed [PW-1:0]     acc_reg;
    logic [LVLW-1:0]          lvl_out_reg;
    logic signed [SW-1:0]     wet_reg;
    logic signed [SW-1:0]     out_sample_reg;
    logic [POS_W-1:0]         out_pos_reg;

    logic [EXTW-1:0]          raw_len;
    logic [LW-1:0]            cur_len;
    logic [CNTW-1:0]          cur_full;
    logic [CNTW-1:0]          cur_ramp;
    logic [LVLW-1:0]          cur_step;
    logic [GW-1:0]            cur_wg;
    logic [AW-1:0]            wp_eff;
    logic [AW-1:0]            wp_adv;

    logic signed [SW-1:0]     mul_a;
    logic signed [MB-1:0]     mul_b;
    logic signed [PW-1:0]     mul_p;

    logic signed [PW-1:0]     fb_round;
    logic signed [PW-1:0]     st_sum;
    logic signed [SW-1:0]     stored;
    logic signed [SW-1:0]     delayed;
    logic signed [PW-1:0]     wet_round;
    logic signed [PW-1:0]     mix_round;

    logic [LVLW:0]            lvl_sum;
    logic [LVLW-1:0]          lvl_up;
    logic [LVLW-1:0]          lvl_down;
    logic [CNTW-1:0]          cnt_win;
    logic [LVLW-1:0]          level_win;
    logic [LVLW-1:0]          win_val;

    logic                     accept;
    logic                     out_load;

    assign raw_len = EXTW'(cfg.delay_length);

    always_comb
    begin
        if (raw_len < EXTW'(rdc_pkg::MIN_LEN))
        begin
            cur_len = LW'(rdc_pkg::MIN_LEN);
        end
        else if (raw_len > EXTW'(MAX_DELAY))
        begin
            cur_len = LW'(MAX_DELAY);
        end
        else
        begin
            cur_len = LW'(raw_len);
        end
    end

    assign cur_full = CNTW'(cur_len >> 1);
    assign cur_ramp = (RW'(cfg.window_ramp) > RW'(cur_full)) ? cur_full
                                                             : CNTW'(cfg.window_ramp);
    assign cur_step = (cfg.window_step > rdc_pkg::UNITY_Q23) ? rdc_pkg::UNITY_Q23
                                                             : cfg.window_step;
    assign cur_wg = (cfg.mix_wet > rdc_pkg::GAIN_UNITY) ? rdc_pkg::GAIN_UNITY
                                                        : cfg.mix_wet;
    assign wp_eff = (LW'(wp_reg) >= cur_len) ? '0 : wp_reg;
    assign wp_adv = tap_ok_reg ? wp_reg + 1'b1 : '0;

    assign in_ready = (state_reg == rdc_pkg::S_IDLE);
    assign accept = in_valid && in_ready;
    assign out_load = (state_reg == rdc_pkg::S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        mul_a = x_reg;
        mul_b = '0;
        case (state_reg)
            rdc_pkg::S_FB:
            begin
                mul_a = feedback_reg;
                mul_b = MB'(cfg.feedback_gain);
            end
            rdc_pkg::S_STORE:
            begin
                mul_a = x_reg;
                mul_b = MB'(rdc_pkg::GAIN_UNITY - wg_reg);
            end
            rdc_pkg::S_WIN:
            begin
                mul_a = feedback_reg;
                mul_b = MB'(lvl_out_reg);
            end
            rdc_pkg::S_MIX:
            begin
                mul_a = wet_reg;
                mul_b = MB'(wg_reg);
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign fb_round = (prod_reg + RND16) >>> 16;
    assign st_sum = fb_round + PW'(x_reg);
    assign stored = sat_fn(st_sum);
    assign delayed = tap_ok_reg ? $signed(ram_rdata) : '0;
    assign wet_round = (prod_reg + RND23) >>> 23;
    assign mix_round = (acc_reg + prod_reg + RND16) >>> 16;

    assign lvl_sum = {1'b0, level_reg} + {1'b0, step_reg};
    assign lvl_up = (lvl_sum > {1'b0, rdc_pkg::UNITY_Q23}) ? rdc_pkg::UNITY_Q23
                                                           : lvl_sum[LVLW-1:0];
    assign lvl_down = (level_reg > step_reg) ? level_reg - step_reg : '0;

    always_comb
    begin
        if (cnt_reg < ramp_reg)
        begin
            cnt_win = cnt_reg + 1'b1;
            level_win = lvl_up;
            win_val = lvl_up;
        end
        else if (cnt_reg <= fmr_reg)
        begin
            cnt_win = cnt_reg + 1'b1;
            level_win = level_reg;
            win_val = rdc_pkg::UNITY_Q23;
        end
        else if (cnt_reg < full_reg)
        begin
            cnt_win = cnt_reg + 1'b1;
            level_win = lvl_down;
            win_val = lvl_down;
        end
        else
        begin
            cnt_win = '0;
            level_win = '0;
            win_val = level_reg;
        end
    end

    assign ram_we = (state_reg == rdc_pkg::S_CLEAR) || (state_reg == rdc_pkg::S_STORE);
    assign ram_waddr = (state_reg == rdc_pkg::S_CLEAR) ? clr_reg : wp_reg;
    assign ram_wdata = (state_reg == rdc_pkg::S_CLEAR) ? '0 : stored;
    assign ram_raddr = AW'(len_reg - LW'(1) - LW'(wp_reg));

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            rdc_pkg::S_CLEAR:
            begin
                if (clr_reg == AW'(MAX_DELAY - 1))
                begin
                    state_next = rdc_pkg::S_IDLE;
                end
            end
            rdc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rdc_pkg::S_FB;
                end
            end
            rdc_pkg::S_FB:    state_next = rdc_pkg::S_STORE;
            rdc_pkg::S_STORE: state_next = rdc_pkg::S_WIN;
            rdc_pkg::S_WIN:   state_next = rdc_pkg::S_WET;
            rdc_pkg::S_WET:   state_next = rdc_pkg::S_MIX;
            rdc_pkg::S_MIX:   state_next = rdc_pkg::S_DONE;
            rdc_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = rdc_pkg::S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = rdc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rdc_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
            clr_reg <= '0;
            wp_reg <= '0;
            cnt_reg <= '0;
            level_reg <= '0;
            feedback_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == rdc_pkg::S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (restart)
            begin
                wp_reg <= '0;
                cnt_reg <= '0;
                level_reg <= '0;
            end
            else if (accept)
            begin
                wp_reg <= wp_eff;
            end
            else if (state_reg == rdc_pkg::S_STORE)
            begin
                wp_reg <= wp_adv;
                cnt_reg <= cnt_win;
                level_reg <= level_win;
            end
            if (state_reg == rdc_pkg::S_STORE)
            begin
                feedback_reg <= delayed;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= in_sample;
            pos_reg <= POS_W'(wp_eff);
            len_reg <= cur_len;
            full_reg <= cur_full;
            ramp_reg <= cur_ramp;
            step_reg <= cur_step;
            wg_reg <= cur_wg;
        end
        case (state_reg)
            rdc_pkg::S_FB:
            begin
                prod_reg <= mul_p;
                fmr_reg <= full_reg - ramp_reg;
                tap_ok_reg <= (LW'(wp_reg) + LW'(1)) < len_reg;
            end
            rdc_pkg::S_STORE:
            begin
                acc_reg <= mul_p;
                lvl_out_reg <= win_val;
            end
            rdc_pkg::S_WIN:
            begin
                prod_reg <= mul_p;
            end
            rdc_pkg::S_WET:
            begin
                wet_reg <= sat_fn(wet_round);
            end
            rdc_pkg::S_MIX:
            begin
                prod_reg <= mul_p;
            end
            rdc_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    out_sample_reg <= sat_fn(mix_round);
                    out_pos_reg <= pos_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign delay_position = out_pos_reg;

    `RDC_CHECK(a_wp_in_chunk, state_reg == rdc_pkg::S_IDLE, LW'(wp_reg) < cur_len)
    `RDC_CHECK(a_level_capped, 1'b1, level_reg <= rdc_pkg::UNITY_Q23)
    `RDC_CHECK(a_no_item_in_clear, state_reg == rdc_pkg::S_CLEAR, !in_ready && !ram_wdata[0])
    `RDC_CHECK_NEXT(a_accept_starts, accept, state_reg == rdc_pkg::S_FB)
    `RDC_CHECK(a_result_from_done, $rose(out_valid_reg), $past(state_reg) == rdc_pkg::S_DONE)

endmodule
